// File: hdl/amds_pkg.sv
// Package for the alpha-aware 2x2 mip downsample block.
// Holds field widths, alpha thresholds and the struct that carries an item
// through the division stages. Depends on nothing.
package amds_pkg;

    // Field and datapath widths.
    localparam int PIXEL_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int NUM_PIX  = 4;
    localparam int NUM_CHAN = 3;
    localparam int ALPHA_LSB = 24;
    localparam int PROD_W   = 2 * CHAN_W;
    // Four products of at most 255*255 fit in 18 bits.
    localparam int CSUM_W   = PROD_W + 2;
    // Four alphas of at most 255 fit in 10 bits.
    localparam int WSUM_W   = CHAN_W + 2;
    localparam int QUOT_W   = CHAN_W;
    // Divisor aligned to the top quotient bit.
    localparam int DSHIFT_W = WSUM_W + QUOT_W - 1;
    // Number of division stages, two quotient bits each.
    localparam int DIV_STAGES = QUOT_W / 2;

    // Alpha thresholds and result constants.
    localparam logic [WSUM_W-1:0] OPAQUE_SUM_MIN    = 10'd510;
    localparam logic [CHAN_W-1:0] QUALIFY_ALPHA_MIN = 8'd128;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR       = 8'd0;

    // Payload of an item in the division pipeline.
    typedef struct packed {
        logic                                opaque;
        logic [DSHIFT_W-1:0]                 dshift;
        logic [NUM_CHAN-1:0][CSUM_W-1:0]     rem;
        logic [NUM_CHAN-1:0][QUOT_W-1:0]     quot;
    } div_t;

endpackage

// File: hdl/amds_weight.sv
// Front of the downsample pipeline: alpha qualification, products and sums.
// Two register stages; hands a div_t item to the division stages.
// Depends on amds_pkg.
module amds_weight
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              advance,
    input  logic                                              in_valid,
    input  logic [amds_pkg::NUM_PIX-1:0][amds_pkg::PIXEL_W-1:0] pixels,
    output logic                                              valid,
    output amds_pkg::div_t                                    item
);
    import amds_pkg::*;

    logic [NUM_PIX-1:0][NUM_CHAN-1:0][PROD_W-1:0] prod_next;
    logic [NUM_PIX-1:0][NUM_CHAN-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_PIX-1:0][CHAN_W-1:0]               weight_next;
    logic [NUM_PIX-1:0][CHAN_W-1:0]               weight_reg;
    logic                                         opaque_next;
    logic                                         opaque_reg;
    logic                                         valid1_reg;
    logic                                         valid2_reg;
    div_t                                         item_next;
    div_t                                         item_reg;

    // Stage one: qualifying alphas, per-channel products and the opacity test.
    always_comb
    begin
        logic [CHAN_W-1:0] alpha;
        logic [WSUM_W-1:0] asum;
        asum = '0;
        for (int p = 0; p < NUM_PIX; p++)
        begin
            alpha = pixels[p][ALPHA_LSB +: CHAN_W];
            asum  = asum + WSUM_W'(alpha);
            weight_next[p] = (alpha >= QUALIFY_ALPHA_MIN) ? alpha : '0;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                prod_next[p][c] = PROD_W'(pixels[p][c*CHAN_W +: CHAN_W]) *
                                  PROD_W'(weight_next[p]);
            end
        end
        opaque_next = (asum >= OPAQUE_SUM_MIN);
    end

    // Stage two: weighted color sums and the weight sum.
    always_comb
    begin
        logic [WSUM_W-1:0] wsum;
        wsum = '0;
        item_next = '0;
        for (int p = 0; p < NUM_PIX; p++)
        begin
            wsum = wsum + WSUM_W'(weight_reg[p]);
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            item_next.rem[c] = CSUM_W'(prod_reg[0][c]) + CSUM_W'(prod_reg[1][c]) +
                               CSUM_W'(prod_reg[2][c]) + CSUM_W'(prod_reg[3][c]);
        end
        item_next.opaque = opaque_reg;
        item_next.dshift = {wsum, {(QUOT_W-1){1'b0}}};
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            weight_reg <= weight_next;
            opaque_reg <= opaque_next;
            item_reg   <= item_next;
        end
    end

    assign valid = valid2_reg;
    assign item  = item_reg;

endmodule

// File: hdl/amds_div_stage.sv
// One stage of the restoring divider: two quotient bits for all three channels.
// The aligned divisor moves right by two bits per stage.
// Depends on amds_pkg.
module amds_div_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  amds_pkg::div_t in_item,
    output logic           valid,
    output amds_pkg::div_t item
);
    import amds_pkg::*;

    logic valid_reg;
    div_t item_next;
    div_t item_reg;

    // Two compare-and-subtract steps per channel.
    always_comb
    begin
        logic [CSUM_W-1:0] r;
        logic [QUOT_W-1:0] q;
        logic [CSUM_W-1:0] d_hi;
        logic [CSUM_W-1:0] d_lo;
        d_hi = CSUM_W'(in_item.dshift);
        d_lo = CSUM_W'(in_item.dshift >> 1);
        item_next = in_item;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            r = in_item.rem[c];
            q = in_item.quot[c];
            if (r >= d_hi)
            begin
                r = r - d_hi;
                q = {q[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[QUOT_W-2:0], 1'b0};
            end
            if (r >= d_lo)
            begin
                r = r - d_lo;
                q = {q[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[QUOT_W-2:0], 1'b0};
            end
            item_next.rem[c]  = r;
            item_next.quot[c] = q;
        end
        item_next.dshift = in_item.dshift >> 2;
    end

    // Valid bit travels with the item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: hdl/alpha_aware_mip_downsample.sv
// Alpha-aware 2x2 mip downsample: an alpha-weighted box filter.
//
// Input channel: one item is one 2x2 quad of RGBA8 pixels (red in bits 7:0,
// alpha in 31:24), taken at a rising edge with quad_valid high and
// quad_stall low. Output channel: one RGBA8 pixel per quad on out_red,
// out_green, out_blue and out_alpha, handed over with pixel_valid high and
// pixel_stall low.
// A quad whose four alphas sum to 510 or more gives alpha 255 and color
// floor(sum(C*A)/sum(A)) over pixels with alpha of at least 128; any other
// quad gives transparent black.
// Two register stages form the products and sums, and four stages of a
// restoring divider settle two quotient bits each; the last divider
// register is the output register.
// Throughput is one quad per cycle. The pipeline moves as one unit: while
// a result waits under pixel_stall, quad_stall is high and every stage
// holds, so nothing is lost or repeated.
// Reset clears all valid bits; the block takes items as soon as reset is
// released.
// Depends on amds_pkg, amds_weight and amds_div_stage.
module alpha_aware_mip_downsample
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quad_valid,
    output logic                          quad_stall,
    input  logic [amds_pkg::PIXEL_W-1:0]  top_left_pixel,
    input  logic [amds_pkg::PIXEL_W-1:0]  top_right_pixel,
    input  logic [amds_pkg::PIXEL_W-1:0]  bottom_left_pixel,
    input  logic [amds_pkg::PIXEL_W-1:0]  bottom_right_pixel,
    output logic                          pixel_valid,
    input  logic                          pixel_stall,
    output logic [amds_pkg::CHAN_W-1:0]   out_red,
    output logic [amds_pkg::CHAN_W-1:0]   out_green,
    output logic [amds_pkg::CHAN_W-1:0]   out_blue,
    output logic [amds_pkg::CHAN_W-1:0]   out_alpha
);
    import amds_pkg::*;

    logic                               advance;
    logic [NUM_PIX-1:0][PIXEL_W-1:0]    pixels;
    logic [DIV_STAGES:0]                stage_valid;
    div_t                               stage_item [DIV_STAGES+1];
    div_t                               last_item;

    // The whole pipeline holds while a finished result is not taken.
    assign advance    = !(pixel_valid && pixel_stall);
    assign quad_stall = !advance;

    assign pixels = {bottom_right_pixel, bottom_left_pixel,
                     top_right_pixel, top_left_pixel};

    // Products, sums and opacity.
    amds_weight u_weight
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (quad_valid),
        .pixels   (pixels),
        .valid    (stage_valid[0]),
        .item     (stage_item[0])
    );

    // Divider stages, two quotient bits each.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        amds_div_stage u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (stage_valid[s]),
            .in_item  (stage_item[s]),
            .valid    (stage_valid[s+1]),
            .item     (stage_item[s+1])
        );
    end

    // Transparent quads come out as black with alpha zero.
    assign last_item   = stage_item[DIV_STAGES];
    assign pixel_valid = stage_valid[DIV_STAGES];
    assign out_red     = last_item.opaque ? last_item.quot[0] : '0;
    assign out_green   = last_item.opaque ? last_item.quot[1] : '0;
    assign out_blue    = last_item.opaque ? last_item.quot[2] : '0;
    assign out_alpha   = last_item.opaque ? ALPHA_OPAQUE : ALPHA_CLEAR;

endmodule

// File: bench/tb_alpha_aware_mip_downsample.sv
`timescale 1ns / 1ps
// Testbench for alpha_aware_mip_downsample. It streams 2x2 RGBA8 quads with bursty input
// and a patterned output stall, predicts each averaged pixel and checks it field by field.
// Depends on amds_pkg and the block's RTL.
module tb_alpha_aware_mip_downsample;
    import amds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 24;
    localparam int RANDOM_QUADS   = 1050;

    typedef logic [NUM_PIX-1:0][PIXEL_W-1:0] quad_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    typedef struct {
        int    serial;
        rgba_t pixel;
    } expected_pixel_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               quad_valid = 1'b0;
    logic               quad_stall;
    logic [PIXEL_W-1:0] top_left_pixel = '0;
    logic [PIXEL_W-1:0] top_right_pixel = '0;
    logic [PIXEL_W-1:0] bottom_left_pixel = '0;
    logic [PIXEL_W-1:0] bottom_right_pixel = '0;
    logic               pixel_valid;
    logic               pixel_stall = 1'b0;
    logic [CHAN_W-1:0]  out_red;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_alpha;

    expected_pixel_t expected_pixels[$];
    int              quads_accepted = 0;
    int              error_count = 0;
    int              burst_left = 0;
    bit              sender_steady = 1'b0;
    stall_mode_t     stall_mode = STALL_NONE;
    int              stall_phase_left = 0;
    int              quiet_cycles = 0;

    alpha_aware_mip_downsample dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .quad_valid         (quad_valid),
        .quad_stall         (quad_stall),
        .top_left_pixel     (top_left_pixel),
        .top_right_pixel    (top_right_pixel),
        .bottom_left_pixel  (bottom_left_pixel),
        .bottom_right_pixel (bottom_right_pixel),
        .pixel_valid        (pixel_valid),
        .pixel_stall        (pixel_stall),
        .out_red            (out_red),
        .out_green          (out_green),
        .out_blue           (out_blue),
        .out_alpha          (out_alpha)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Alpha-weighted average of one quad, in exact integer arithmetic.
    function automatic rgba_t predict_downsample(input quad_t quad);
        int unsigned alpha_sum;
        int unsigned weight_sum;
        int unsigned red_sum;
        int unsigned green_sum;
        int unsigned blue_sum;
        int unsigned alpha;
        rgba_t       result;
        int          i;
        alpha_sum  = 0;
        weight_sum = 0;
        red_sum    = 0;
        green_sum  = 0;
        blue_sum   = 0;
        result     = '0;
        result.alpha = ALPHA_CLEAR;
        for (i = 0; i < NUM_PIX; i++)
            alpha_sum += quad[i][ALPHA_LSB +: CHAN_W];
        // A transparent quad gives black with alpha cleared.
        if (alpha_sum >= OPAQUE_SUM_MIN)
        begin
            for (i = 0; i < NUM_PIX; i++)
            begin
                alpha = quad[i][ALPHA_LSB +: CHAN_W];
                if (alpha >= QUALIFY_ALPHA_MIN)
                begin
                    red_sum    += quad[i][0 +: CHAN_W] * alpha;
                    green_sum  += quad[i][CHAN_W +: CHAN_W] * alpha;
                    blue_sum   += quad[i][2*CHAN_W +: CHAN_W] * alpha;
                    weight_sum += alpha;
                end
            end
            if (weight_sum != 0)
            begin
                result.red   = CHAN_W'(red_sum / weight_sum);
                result.green = CHAN_W'(green_sum / weight_sum);
                result.blue  = CHAN_W'(blue_sum / weight_sum);
            end
            result.alpha = ALPHA_OPAQUE;
        end
        return result;
    endfunction

    function automatic logic [PIXEL_W-1:0] make_pixel(input logic [CHAN_W-1:0] alpha,
                                                      input logic [CHAN_W-1:0] red,
                                                      input logic [CHAN_W-1:0] green,
                                                      input logic [CHAN_W-1:0] blue);
        return {alpha, blue, green, red};
    endfunction

    function automatic quad_t make_quad(input logic [PIXEL_W-1:0] tl,
                                        input logic [PIXEL_W-1:0] tr,
                                        input logic [PIXEL_W-1:0] bl,
                                        input logic [PIXEL_W-1:0] br);
        quad_t quad;
        quad[0] = tl;
        quad[1] = tr;
        quad[2] = bl;
        quad[3] = br;
        return quad;
    endfunction

    // Random pixel with alphas clustered around the thresholds and some extreme colors.
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [CHAN_W-1:0]   alpha;
        logic [3*CHAN_W-1:0] color;
        case ($urandom_range(0, 4))
            0:       alpha = CHAN_W'($urandom_range(0, 255));
            1:       alpha = CHAN_W'($urandom_range(118, 138));
            2:       alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: alpha = CHAN_W'($urandom_range(64, 200));
        endcase
        case ($urandom_range(0, 7))
            0:       color = '0;
            1:       color = '1;
            default: color = (3*CHAN_W)'($urandom());
        endcase
        return {alpha, color};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Lowers valid, puts junk on the payload and waits the given number of cycles.
    task automatic idle_sender(input int cycles);
        quad_valid         <= 1'b0;
        top_left_pixel     <= $urandom();
        top_right_pixel    <= $urandom();
        bottom_left_pixel  <= $urandom();
        bottom_right_pixel <= $urandom();
        repeat (cycles) @(posedge clk);
    endtask

    // Sends one quad, records its expected pixel, then keeps to the burst pattern.
    task automatic send_quad(input quad_t quad);
        expected_pixel_t entry;
        quad_valid         <= 1'b1;
        top_left_pixel     <= quad[0];
        top_right_pixel    <= quad[1];
        bottom_left_pixel  <= quad[2];
        bottom_right_pixel <= quad[3];
        @(posedge clk);
        while (quad_stall)
            @(posedge clk);
        entry.serial = quads_accepted;
        entry.pixel  = predict_downsample(quad);
        expected_pixels.insert(expected_pixels.size(), entry);
        quads_accepted++;
        if (!sender_steady)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                idle_sender($urandom_range(1, 6));
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // Holds the sender off until every pending pixel has come out.
    task automatic drain_results();
        idle_sender(1);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_transparent_quads();
        send_quad(make_quad(32'h0, 32'h0, 32'h0, 32'h0));
        send_quad(make_quad(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF));
        // Alpha sum of 509 falls one short of opaque.
        send_quad(make_quad(make_pixel(127, 200, 10, 90), make_pixel(127, 30, 250, 60),
                            make_pixel(127, 255, 255, 255), make_pixel(128, 1, 2, 3)));
        send_quad(make_quad(make_pixel(255, 255, 255, 255), make_pixel(254, 255, 0, 255),
                            make_pixel(0, 77, 88, 99), make_pixel(0, 255, 255, 255)));
    endtask

    task automatic test_opaque_threshold();
        // Alpha sum of exactly 510 from two opaque pixels.
        send_quad(make_quad(make_pixel(255, 200, 100, 50), make_pixel(255, 10, 20, 30),
                            make_pixel(0, 255, 255, 255), make_pixel(0, 255, 255, 255)));
        // Sum of 510 where the alphas of 127 do not qualify.
        send_quad(make_quad(make_pixel(128, 255, 0, 17), make_pixel(128, 0, 255, 240),
                            make_pixel(127, 255, 255, 255), make_pixel(127, 255, 255, 255)));
        // Only one pixel qualifies, so its color passes through.
        send_quad(make_quad(make_pixel(85, 0, 0, 0), make_pixel(255, 123, 45, 210),
                            make_pixel(85, 255, 255, 255), make_pixel(85, 9, 9, 9)));
        send_quad(make_quad(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_quad(make_quad(32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000));
    endtask

    task automatic test_weighted_average();
        // Quotient that must be floored: 255*255/383.
        send_quad(make_quad(make_pixel(255, 255, 255, 255), make_pixel(128, 0, 0, 0),
                            make_pixel(127, 0, 0, 0), make_pixel(0, 0, 0, 0)));
        send_quad(make_quad(make_pixel(200, 10, 20, 30), make_pixel(150, 250, 240, 230),
                            make_pixel(130, 128, 127, 1), make_pixel(140, 99, 0, 255)));
        send_quad(make_quad(make_pixel(128, 255, 0, 0), make_pixel(128, 0, 255, 0),
                            make_pixel(128, 0, 0, 255), make_pixel(128, 255, 255, 255)));
        send_quad(make_quad(make_pixel(255, 1, 254, 128), make_pixel(129, 254, 1, 127),
                            make_pixel(126, 255, 255, 255), make_pixel(255, 0, 0, 0)));
    endtask

    // Random quads, alternating bursty and steady stretches, with a full drain halfway.
    task automatic test_random_quads(input int count);
        quad_t quad;
        int    i;
        int    p;
        for (i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                sender_steady = ((i / 150) % 3 == 1);
            if (i == count / 2)
                drain_results();
            for (p = 0; p < NUM_PIX; p++)
                quad[p] = random_pixel();
            send_quad(quad);
        end
        sender_steady = 1'b0;
    endtask

    // Receiver stall pattern: modes of random length, from no stall to heavy stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
        end
        else
        begin
            if (stall_phase_left == 0)
            begin
                stall_mode       = stall_mode_t'($urandom_range(0, 3));
                stall_phase_left = $urandom_range(16, 96);
            end
            else
                stall_phase_left--;
            case (stall_mode)
                STALL_NONE:     pixel_stall <= 1'b0;
                STALL_RANDOM:   pixel_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: pixel_stall <= (stall_phase_left % 3 == 0);
                default:        pixel_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Compares each accepted pixel with the oldest expected one.
    always @(posedge clk)
    begin : check_pixel
        expected_pixel_t entry;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("pixel with none expected: r=%0d g=%0d b=%0d a=%0d",
                                          out_red, out_green, out_blue, out_alpha));
            else
            begin
                entry = expected_pixels.pop_front();
                if (out_red !== entry.pixel.red)
                    report_mismatch($sformatf("item %0d red: expected %0d, got %0d",
                                              entry.serial, entry.pixel.red, out_red));
                if (out_green !== entry.pixel.green)
                    report_mismatch($sformatf("item %0d green: expected %0d, got %0d",
                                              entry.serial, entry.pixel.green, out_green));
                if (out_blue !== entry.pixel.blue)
                    report_mismatch($sformatf("item %0d blue: expected %0d, got %0d",
                                              entry.serial, entry.pixel.blue, out_blue));
                if (out_alpha !== entry.pixel.alpha)
                    report_mismatch($sformatf("item %0d alpha: expected %0d, got %0d",
                                              entry.serial, entry.pixel.alpha, out_alpha));
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((quad_valid && !quad_stall) || (pixel_valid && !pixel_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_transparent_quads();
        test_opaque_threshold();
        test_weighted_average();
        drain_results();
        test_random_quads(RANDOM_QUADS);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
